// ===== design/assert_macros.svh =====
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lfowah_pkg.sv =====
// package: constants, register indexes and sine table builder of the wah filter
package lfowah_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int PHASE_W     = 32;
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_ADDR_W = 10;
    localparam int COEF_FRAC   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int FS_W        = 18;
    localparam int HZ_W        = 15;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam logic [30:0]     TWO_PI_Q28  = 31'd1686629713;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_CUTOFF  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CUTOFF  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_RATE    = 3'd3;

    // reset values
    localparam logic [FS_W-1:0] FS_RESET      = 18'd48000;
    localparam logic [HZ_W-1:0] MIN_RESET     = 15'd500;
    localparam logic [HZ_W-1:0] MAX_RESET     = 15'd3000;
    localparam logic [HZ_W-1:0] LFO_RESET     = 15'd200;

    typedef logic [15:0] sine_tab_t [0:SINE_DEPTH];

    // quarter-wave sine in unsigned q1.15, integer taylor series up to x^15
    function automatic sine_tab_t build_sine_table();
        sine_tab_t          t;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint             sum;
        longint             r;
        int                 i;
        for (i = 0; i <= SINE_DEPTH; i++)
        begin
            x    = (PI_HALF_Q30 * longint'(i)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            // series terms x^3/3! .. x^15/15!, each divided by (2n)(2n+1)
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 210;
            sum  = sum - longint'(term);
            if (sum < 0)
                sum = 0;
            r = (sum + 64'sd16384) >>> 15;
            if (r > 32768)
                r = 32768;
            t[i] = 16'(r);
        end
        return t;
    endfunction

endpackage

// ===== design/lfowah_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module lfowah_mul #(
    parameter int AW = 31,
    parameter int BW = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] product
);

    localparam int CW = $clog2(AW + 1);

    logic [AW+BW-1:0] prod_reg, prod_next;
    logic [BW-1:0]    mcand_reg, mcand_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [BW:0]      sum;

    always_comb
    begin
        sum        = {1'b0, prod_reg[AW+BW-1:AW]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            prod_next  = {{BW{1'b0}}, a};
            mcand_next = b;
            cnt_next   = CW'(AW);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[AW-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

// ===== design/lfowah_div.sv =====
// restoring divider, one quotient bit per cycle
module lfowah_div #(
    parameter int NW = 51,
    parameter int DW = 35,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic          fits;

    // top dividend bits seed the remainder, they must stay below the divisor
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QW-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = DW'(dividend[NW-1:QW]);
            quo_next  = dividend[QW-1:0];
            dvs_next  = divisor;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_next  = {quo_reg[QW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/lfo_swept_lowpass_wah.sv =====
// top level: lfo swept one-pole low-pass (wah) with bit-serial coefficient path
// steps: a setup state, a serial multiply for 2*pi*fc, a restoring divide for k,
//   then the filter and update states
// input: a new sample is accepted only in idle, so an output stall holds it off;
//   the phase increment divider (38 steps) runs alongside and never holds up a sample
// reset: asynchronous active low, clears filter, lfo phase, handshakes, loads defaults
module lfo_swept_lowpass_wah
    import lfowah_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    sample_in,
    input  logic                   last_in,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_W-1:0]    sample_out,
    output logic                   last_out
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_FC,
        S_MUL,
        S_DIV,
        S_FILT,
        S_UPD
    } state_t;

    localparam sine_tab_t SINE_TABLE = build_sine_table();

    // configuration registers
    logic [FS_W-1:0]     fs_reg;
    logic [HZ_W-1:0]     min_reg;
    logic [HZ_W-1:0]     max_reg;
    logic [HZ_W-1:0]     lfo_reg;

    // control and state
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] y_reg, y_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;

    // payload of the item at work
    logic [SAMPLE_W-1:0] x_reg;
    logic                last_reg;
    logic [15:0]         sine_q_reg;
    logic                sine_neg_reg;
    logic signed [42:0]  d_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;
    logic                last_out_reg;

    // sine lookup
    logic [SINE_ADDR_W-1:0] quad_idx;
    logic [SINE_ADDR_W:0]   sine_addr;

    // cutoff
    logic [16:0]         u;
    logic signed [15:0]  dmax;
    logic signed [33:0]  fc_base;
    logic signed [33:0]  fc_prod;
    logic signed [33:0]  fc_full;
    logic [30:0]         fcq;

    // coefficient path
    logic                mul_start, mul_busy;
    logic [61:0]         mul_prod;
    logic [33:0]         w;
    logic [17:0]         fs_eff;
    logic [34:0]         den;
    logic [50:0]         k_num;
    logic                k_start, k_busy;
    logic [16:0]         k_q;

    // phase increment
    logic [27:0]         inc_den;
    logic [46:0]         inc_num;
    logic                inc_start, inc_busy;
    logic [37:0]         inc_q;

    // filter update
    logic signed [24:0]  diff;
    logic signed [42:0]  d_calc;
    logic [42:0]         d_abs;
    logic [42:0]         d_rnd;
    logic [SAMPLE_W-1:0] step;

    logic                in_fire;
    logic                out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign fs_eff   = (fs_reg == '0) ? 18'd1 : fs_reg;

    // quarter-wave addressing: odd quadrants run the table backwards,
    // the upper half-turn negates
    assign quad_idx  = phase_reg[PHASE_W-3 -: SINE_ADDR_W];
    assign sine_addr = phase_reg[PHASE_W-2]
                     ? (11'(SINE_DEPTH) - {1'b0, quad_idx})
                     : {1'b0, quad_idx};

    // fc in q16 hz: min + u * (max - min), u = (1 + sin) / 2 in q16
    assign u       = sine_neg_reg ? (17'd32768 - {1'b0, sine_q_reg})
                                  : (17'd32768 + {1'b0, sine_q_reg});
    assign dmax    = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign fc_base = $signed({3'b0, min_reg, 16'b0});
    assign fc_prod = $signed({1'b0, u}) * dmax;
    assign fc_full = fc_base + fc_prod;
    assign fcq     = fc_full[30:0];

    // 2*pi*fc and the rounded divide for k
    assign w     = mul_prod[61:28];
    assign den   = {1'b0, fs_eff, 16'b0} + 35'(w);
    assign k_num = 51'({w, 16'b0}) + 51'(den[34:1]);

    // phase increment: lfo * 2^32 / (1000 * fs), kept modulo the phase width
    assign inc_den = 28'(fs_eff) * 28'd1000;
    assign inc_num = {lfo_reg, 32'b0};

    assign mul_start = (state_reg == S_FC);
    assign k_start   = (state_reg == S_MUL) && !mul_busy;
    assign inc_start = in_fire;

    lfowah_mul #(
        .AW (31),
        .BW (31)
    ) u_wmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (fcq),
        .b       (TWO_PI_Q28),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    lfowah_div #(
        .NW (51),
        .DW (35),
        .QW (17)
    ) u_kdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (k_start),
        .dividend (k_num),
        .divisor  (den),
        .busy     (k_busy),
        .quotient (k_q)
    );

    lfowah_div #(
        .NW (47),
        .DW (28),
        .QW (38)
    ) u_incdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (inc_start),
        .dividend (inc_num),
        .divisor  (inc_den),
        .busy     (inc_busy),
        .quotient (inc_q)
    );

    // y += k * (x - y), rounded half away from zero
    assign diff   = $signed({x_reg[SAMPLE_W-1], x_reg}) - $signed({y_reg[SAMPLE_W-1], y_reg});
    assign d_calc = $signed({1'b0, k_q}) * diff;
    assign d_abs  = d_reg[42] ? 43'(-d_reg) : 43'(d_reg);
    assign d_rnd  = (d_abs + 43'(1 << (COEF_FRAC - 1))) >> COEF_FRAC;
    assign step   = d_reg[42] ? SAMPLE_W'(-d_rnd) : SAMPLE_W'(d_rnd);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        y_next         = y_reg;
        phase_next     = phase_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_FC;
            end
            S_FC:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (!mul_busy)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!k_busy)
                    state_next = S_FILT;
            end
            S_FILT:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    y_next         = y_reg + step;
                    phase_next     = phase_reg + inc_q[PHASE_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            y_reg         <= '0;
            phase_reg     <= '0;
            fs_reg        <= FS_RESET;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            lfo_reg       <= LFO_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            y_reg         <= y_next;
            phase_reg     <= phase_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_RATE: fs_reg  <= cfg_data[FS_W-1:0];
                    REG_MIN_CUTOFF:  min_reg <= cfg_data[HZ_W-1:0];
                    REG_MAX_CUTOFF:  max_reg <= cfg_data[HZ_W-1:0];
                    REG_LFO_RATE:    lfo_reg <= cfg_data[HZ_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        sine_q_reg   <= SINE_TABLE[sine_addr];
        sine_neg_reg <= phase_reg[PHASE_W-1];
        if (in_fire)
        begin
            x_reg    <= sample_in;
            last_reg <= last_in;
        end
        if (state_reg == S_FILT)
            d_reg <= d_calc;
        if (state_reg == S_UPD && out_free)
        begin
            sample_out_reg <= y_reg + step;
            last_out_reg   <= last_reg;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

    `ASSERT_NXT(a_accept_starts, in_fire, state_reg == S_FC, "accepted item did not start")
    `ASSERT_IMP(a_inc_done, state_reg == S_UPD, !inc_busy, "phase increment not ready")
    `ASSERT_IMP(a_coef_range, state_reg == S_FILT, k_q <= 17'd65536, "coefficient above one")

endmodule
